// ----- rtl/fpdi_pkg.sv -----
`default_nettype none
// ============================================================================
// fpdi_pkg - shared types and constants of the parabolic Farrow decimator
// Holds the datapath widths, the group record that travels through the
// queue, and the control group that drives the interpolation lanes.
// ============================================================================
package fpdi_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MU_W     = 16;

  // Group of four samples per channel.
  localparam int GROUP_LEN = 4;

  // Datapath widths: A = x3-x2-x1+x0, B = -x3+3*x2-x1-x0, PA = m*A,
  // P = PA + B*2^MU_W, PM = P*m, Y = x1 + round(PM / 2^(2*MU_W+1)).
  localparam int A_W    = SAMPLE_W + 2;
  localparam int B_W    = SAMPLE_W + 3;
  localparam int PA_W   = A_W + MU_W + 1;
  localparam int P_W    = B_W + MU_W + 1;
  localparam int PM_W   = P_W + MU_W + 1;
  localparam int FRAC_SHIFT = 2 * MU_W + 1;
  localparam int Y_W    = PM_W - FRAC_SHIFT + 1;

  localparam int SAT_MAX = (1 << (SAMPLE_W - 1)) - 1;

  // Adds one half of the final output step before the truncating shift.
  localparam logic signed [PM_W-1:0] ROUND_HALF = PM_W'(1) << (FRAC_SHIFT - 1);

  // Stream payload widths.
  localparam int IN_DATA_W  = 2 * SAMPLE_W + MU_W;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One complete group: index 0 is the oldest sample.
  typedef struct packed {
    logic [GROUP_LEN-1:0][SAMPLE_W-1:0] x_i;
    logic [GROUP_LEN-1:0][SAMPLE_W-1:0] x_q;
    logic [MU_W-1:0]                    mu;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic add;
    logic mul2;
  } lane_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_e;

endpackage
`default_nettype wire

// ----- rtl/fpdi_front.sv -----
`default_nettype none
// ============================================================================
// fpdi_front - input side of the parabolic Farrow decimator
// Accepts complex samples, holds the first three of each group of four and
// pushes the complete group with its mu into the queue on the fourth.
// ============================================================================
module fpdi_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // Fields from bit 0 up: sample_i[15:0], sample_q[15:0], frac_offset[15:0].
  input  wire logic [fpdi_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  wire fpdi_pkg::queue_status_t           q_status_i,
  output logic                                   push_o,
  output fpdi_pkg::group_t                       group_o
);

  logic [1:0] phase_q, phase_d;
  logic [2:0][fpdi_pkg::SAMPLE_W-1:0] held_i_q, held_q_q;
  logic accept;
  logic [fpdi_pkg::SAMPLE_W-1:0] smp_i, smp_q;
  logic [fpdi_pkg::MU_W-1:0]     mu;

  assign smp_i = s_axis_tdata_i[fpdi_pkg::SAMPLE_W-1:0];
  assign smp_q = s_axis_tdata_i[2*fpdi_pkg::SAMPLE_W-1:fpdi_pkg::SAMPLE_W];
  assign mu    = s_axis_tdata_i[fpdi_pkg::IN_DATA_W-1:2*fpdi_pkg::SAMPLE_W];

  // A push only ever happens on an accepted request, so a full queue holds off input.
  assign s_axis_tready_o = !q_status_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = accept && (phase_q == 2'd3);
  assign phase_d         = phase_q + 2'd1;

  always_comb begin
    group_o.x_i = {smp_i, held_i_q[2], held_i_q[1], held_i_q[0]};
    group_o.x_q = {smp_q, held_q_q[2], held_q_q[1], held_q_q[0]};
    group_o.mu  = mu;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 2'd0;
      held_i_q <= '0;
      held_q_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      if (phase_q != 2'd3) begin
        held_i_q[phase_q] <= smp_i;
        held_q_q[phase_q] <= smp_q;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fpdi_queue.sv -----
`default_nettype none
// ============================================================================
// fpdi_queue - short group queue between front and back
// A small first-in first-out store of complete groups so that the input
// side and the arithmetic side can stall independently.
// ============================================================================
module fpdi_queue (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire fpdi_pkg::group_t        data_i,
  input  wire logic                    pop_i,
  output fpdi_pkg::group_t             data_o,
  output fpdi_pkg::queue_status_t      status_o
);

  fpdi_pkg::group_t mem_q [fpdi_pkg::QUEUE_DEPTH];
  logic [fpdi_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [fpdi_pkg::QCNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == fpdi_pkg::QCNT_W'(fpdi_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + fpdi_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - fpdi_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == fpdi_pkg::QPTR_W'(fpdi_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + fpdi_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == fpdi_pkg::QPTR_W'(fpdi_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + fpdi_pkg::QPTR_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fpdi_lane.sv -----
`default_nettype none
// ============================================================================
// fpdi_lane - one channel of the parabolic Farrow arithmetic
// Forms the polynomial coefficients, multiplies by mu twice (mu*A, then
// P*mu, with the B term added between), then rounds and saturates the result.
// ============================================================================
module fpdi_lane (
  input  wire logic                                          clk_i,
  input  wire fpdi_pkg::lane_ctrl_t                          ctrl_i,
  input  wire logic [fpdi_pkg::GROUP_LEN-1:0][fpdi_pkg::SAMPLE_W-1:0] x_i,
  input  wire logic [fpdi_pkg::MU_W-1:0]                     mu_i,
  output logic [fpdi_pkg::SAMPLE_W-1:0]                      y_o
);

  logic signed [fpdi_pkg::B_W-1:0]  x0, x1, x2, x3;
  logic signed [fpdi_pkg::A_W-1:0]  a_d;
  logic signed [fpdi_pkg::B_W-1:0]  b_d;
  logic signed [fpdi_pkg::A_W-1:0]  a_q;
  logic signed [fpdi_pkg::B_W-1:0]  b_q;
  logic signed [fpdi_pkg::SAMPLE_W-1:0] x1_q;
  logic signed [fpdi_pkg::MU_W:0]   mu_q;
  logic signed [fpdi_pkg::PA_W-1:0] pa_q;
  logic signed [fpdi_pkg::P_W-1:0]  p_q;
  logic signed [fpdi_pkg::PM_W-1:0] pm_q;
  logic signed [fpdi_pkg::PM_W-1:0] rounded;
  logic signed [fpdi_pkg::Y_W-1:0]  y_full;
  logic signed [fpdi_pkg::Y_W-1:0]  y_max, y_min;

  assign x0 = fpdi_pkg::B_W'($signed(x_i[0]));
  assign x1 = fpdi_pkg::B_W'($signed(x_i[1]));
  assign x2 = fpdi_pkg::B_W'($signed(x_i[2]));
  assign x3 = fpdi_pkg::B_W'($signed(x_i[3]));

  // A fits in A_W bits; B needs one more bit for the factor of three.
  assign a_d = fpdi_pkg::A_W'(x3 - x2 - x1 + x0);
  assign b_d = (x2 <<< 1) + x2 - x3 - x1 - x0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q  <= a_d;
      b_q  <= b_d;
      x1_q <= $signed(x_i[1]);
      mu_q <= $signed({1'b0, mu_i});
    end
    if (ctrl_i.mul1) begin
      pa_q <= fpdi_pkg::PA_W'(a_q * mu_q);
    end
    if (ctrl_i.add) begin
      p_q <= fpdi_pkg::P_W'(pa_q) + (fpdi_pkg::P_W'(b_q) <<< fpdi_pkg::MU_W);
    end
    if (ctrl_i.mul2) begin
      pm_q <= fpdi_pkg::PM_W'(p_q * mu_q);
    end
  end

  // Round to nearest, ties toward plus infinity, then add the base sample.
  assign rounded = pm_q + fpdi_pkg::ROUND_HALF;
  assign y_full  = fpdi_pkg::Y_W'($signed(rounded[fpdi_pkg::PM_W-1:fpdi_pkg::FRAC_SHIFT]))
                 + fpdi_pkg::Y_W'(x1_q);
  assign y_max   = fpdi_pkg::Y_W'(fpdi_pkg::SAT_MAX);
  assign y_min   = -y_max - fpdi_pkg::Y_W'(1);

  always_comb begin
    priority if (y_full > y_max) begin
      y_o = y_max[fpdi_pkg::SAMPLE_W-1:0];
    end else if (y_full < y_min) begin
      y_o = y_min[fpdi_pkg::SAMPLE_W-1:0];
    end else begin
      y_o = y_full[fpdi_pkg::SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fpdi_back.sv -----
`default_nettype none
// ============================================================================
// fpdi_back - arithmetic side of the parabolic Farrow decimator
// Takes groups from the queue, steps both channel lanes through load, mu*A,
// add and P*mu, and holds each result in the output register.
// ============================================================================
module fpdi_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fpdi_pkg::group_t                  group_i,
  input  wire fpdi_pkg::queue_status_t           q_status_i,
  output logic                                   pop_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // Fields from bit 0 up: interp_i[15:0], interp_q[15:0].
  output logic [fpdi_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o
);

  fpdi_pkg::back_state_e state_q, state_d;
  fpdi_pkg::lane_ctrl_t  ctrl;
  logic out_free, out_load;
  logic out_valid_q;
  logic [fpdi_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [fpdi_pkg::SAMPLE_W-1:0]   y_i, y_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      fpdi_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          state_d = fpdi_pkg::ST_MUL1;
        end
      end
      fpdi_pkg::ST_MUL1: state_d = fpdi_pkg::ST_ADD;
      fpdi_pkg::ST_ADD:  state_d = fpdi_pkg::ST_MUL2;
      fpdi_pkg::ST_MUL2: state_d = fpdi_pkg::ST_OUT;
      fpdi_pkg::ST_OUT: begin
        // Hand over the result and start any waiting group in the same cycle.
        if (out_free) begin
          out_load = 1'b1;
          if (!q_status_i.empty) begin
            pop_o   = 1'b1;
            state_d = fpdi_pkg::ST_MUL1;
          end else begin
            state_d = fpdi_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = fpdi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load = pop_o;
    ctrl.mul1 = (state_q == fpdi_pkg::ST_MUL1);
    ctrl.add  = (state_q == fpdi_pkg::ST_ADD);
    ctrl.mul2 = (state_q == fpdi_pkg::ST_MUL2);
  end

  fpdi_lane u_lane_i (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .x_i    (group_i.x_i),
    .mu_i   (group_i.mu),
    .y_o    (y_i)
  );

  fpdi_lane u_lane_q (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .x_i    (group_i.x_q),
    .mu_i   (group_i.mu),
    .y_o    (y_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpdi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {y_q, y_i};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

// ----- rtl/farrow_parabolic_decimating_interpolator.sv -----
`default_nettype none
// Throughput: one input request per cycle while the queue is not full; one
// result for every four inputs. The back end steps each group through mu*A,
// add, P*mu, then the result hand-over, which also loads the next group.
// After the fourth sample of a group is accepted, the group passes through the
// queue, the lane registers and the output register before its result is valid.
// Reset: asynchronous, active low; clears the group phase, queue and output valid.
// ============================================================================
// farrow_parabolic_decimating_interpolator - parabolic Farrow decimator
// Piecewise-parabolic Farrow interpolation (alpha one half) over groups of
// four complex samples, one interpolated complex sample per group.
// ============================================================================
module farrow_parabolic_decimating_interpolator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0 up: sample_i[15:0], sample_q[15:0], frac_offset[15:0].
  input  wire logic [fpdi_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // Fields from bit 0 up: interp_i[15:0], interp_q[15:0].
  output logic [fpdi_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  // The front part counts samples within a group and keeps the three older
  // ones; on the fourth request the whole group, with the mu carried by that
  // request, goes into the queue. A full queue drops s_axis_tready_o.
  fpdi_pkg::queue_status_t q_status;
  fpdi_pkg::group_t        push_group, pop_group;
  logic                    push, pop;

  fpdi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .group_o         (push_group)
  );

  // Two-entry queue of complete groups decouples input from arithmetic.
  fpdi_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_group),
    .pop_i    (pop),
    .data_o   (pop_group),
    .status_o (q_status)
  );

  // The back part evaluates y = x1 + round((m*A + B*2^16)*m / 2^33) in both
  // channels, saturates to 16 bits and presents the result in an output
  // register, so a stalled result does not stop the next group from starting.
  fpdi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .group_i         (pop_group),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// ============================================================================
// testbench - self-checking bench for the parabolic Farrow decimator
// Streams complex samples into the block and predicts one interpolated sample
// for every group of four. Every result is checked against that prediction.
// The run starts with directed groups: saturation at both rails, mu at zero
// and at full scale, rounding ties, and mu ignored off the fourth sample.
// Random groups follow, with idle bursts on both sides, a long output stall,
// and a pause that lets the block drain completely.
// ============================================================================
module testbench;
  import fpdi_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_GROUPS = 462;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 20;

  // Predicts the interpolated output of every complete group of four samples
  // and holds those predictions until the block delivers its results.
  class interp_scoreboard;
    int                    group_pos;
    longint                held_i[3];
    longint                held_q[3];
    logic [OUT_DATA_W-1:0] expected_interp[$];
    int                    samples_taken;
    int                    results_checked;
    int                    saturated;
    int                    errors;

    function new();
      group_pos = 0;
      foreach (held_i[k]) begin
        held_i[k] = 0;
        held_q[k] = 0;
      end
      samples_taken   = 0;
      results_checked = 0;
      saturated       = 0;
      errors          = 0;
    endfunction

    // y = x1 + round((m*A + B*2^MU_W) * m / 2^(2*MU_W+1)), ties toward plus
    // infinity, then clipped to the signed sample range. The largest product
    // stays below 2^51, so 64-bit arithmetic is exact.
    function logic [SAMPLE_W-1:0] parabolic_interp(longint x0, longint x1, longint x2,
                                                   longint x3, longint m);
      longint a, b, p, acc, y;
      a   = x3 - x2 - x1 + x0;
      b   = -x3 + 3 * x2 - x1 - x0;
      p   = m * a + b * (longint'(1) << MU_W);
      acc = p * m + (longint'(1) << (2 * MU_W));
      y   = (acc >>> (2 * MU_W + 1)) + x1;
      if (y > longint'(SAT_MAX)) begin
        y = SAT_MAX;
        saturated++;
      end else if (y < -longint'(SAT_MAX) - 1) begin
        y = -longint'(SAT_MAX) - 1;
        saturated++;
      end
      return y[SAMPLE_W-1:0];
    endfunction

    function void take_sample(logic [IN_DATA_W-1:0] d);
      longint si, sq, mu;
      logic [SAMPLE_W-1:0] yi, yq;
      si = longint'($signed(d[SAMPLE_W-1:0]));
      sq = longint'($signed(d[2*SAMPLE_W-1:SAMPLE_W]));
      mu = longint'(d[IN_DATA_W-1:2*SAMPLE_W]);
      samples_taken++;
      if (group_pos < GROUP_LEN - 1) begin
        held_i[group_pos] = si;
        held_q[group_pos] = sq;
        group_pos++;
      end else begin
        yi = parabolic_interp(held_i[0], held_i[1], held_i[2], si, mu);
        yq = parabolic_interp(held_q[0], held_q[1], held_q[2], sq, mu);
        expected_interp.push_back({yq, yi});
        group_pos = 0;
      end
    endfunction

    function void check_interp(logic [OUT_DATA_W-1:0] d);
      logic [OUT_DATA_W-1:0] want;
      if (expected_interp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h, no interpolation pending", $time, d);
        return;
      end
      want = expected_interp.pop_front();
      results_checked++;
      if (d[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0]) begin
        errors++;
        $display("%0t: interp_i mismatch, expected %0d, actual %0d", $time,
                 $signed(want[SAMPLE_W-1:0]), $signed(d[SAMPLE_W-1:0]));
      end
      if (d[2*SAMPLE_W-1:SAMPLE_W] !== want[2*SAMPLE_W-1:SAMPLE_W]) begin
        errors++;
        $display("%0t: interp_q mismatch, expected %0d, actual %0d", $time,
                 $signed(want[2*SAMPLE_W-1:SAMPLE_W]), $signed(d[2*SAMPLE_W-1:SAMPLE_W]));
      end
    endfunction

    function int pending();
      return expected_interp.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni  = 1'b0;
  logic                  s_valid = 1'b0;
  logic [IN_DATA_W-1:0]  s_data  = '0;
  logic                  s_ready;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;

  // Sender gaps are switched off by the stimulus process itself; the
  // receiver flags are raised on a rising edge and read on a falling one.
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  logic hold_req = 1'b0;
  int   cycle_count = 0;

  interp_scoreboard sb = new();

  farrow_parabolic_decimating_interpolator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so the next call can present a new sample at once.
  task automatic push_sample(logic [SAMPLE_W-1:0] si, logic [SAMPLE_W-1:0] sq,
                             logic [MU_W-1:0] mu);
    if (!tx_quiet && $urandom_range(0, 5) == 0) begin
      s_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {mu, sq, si};
    do @(posedge clk_i); while (!s_ready);
    sb.take_sample(s_data);
    @(negedge clk_i);
  endtask

  // Arrays are packed with the oldest sample in element 0. The first three
  // samples carry random mu codes, which the block must ignore.
  task automatic send_group(logic [GROUP_LEN-1:0][SAMPLE_W-1:0] xi,
                            logic [GROUP_LEN-1:0][SAMPLE_W-1:0] xq,
                            logic [MU_W-1:0] mu);
    for (int k = 0; k < GROUP_LEN - 1; k++)
      push_sample(xi[k], xq[k], MU_W'($urandom));
    push_sample(xi[GROUP_LEN-1], xq[GROUP_LEN-1], mu);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return SAMPLE_W'($urandom_range(0, 7));
      3:       return -SAMPLE_W'($urandom_range(1, 8));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [MU_W-1:0] pick_mu();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return MU_W'(1) << (MU_W - 1);
      default: return MU_W'($urandom);
    endcase
  endfunction

  // Output side: random stalls, plus one long hold-off counted here.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        m_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_ready = 1'b0;
        stall_left--;
      end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
        m_ready    = 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        m_ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready)
      sb.check_interp(m_data);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count, sb.pending());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [GROUP_LEN-1:0][SAMPLE_W-1:0] ri, rq;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Both rails: I overshoots upward, Q downward, at mu one half.
    send_group({16'h8000, 16'h7fff, 16'h7fff, 16'h8000},
               {16'h7fff, 16'h8000, 16'h8000, 16'h7fff}, 16'h8000);
    // Mu of zero returns x1 unchanged, here at each extreme.
    send_group({16'h0001, 16'h7fff, 16'h8000, 16'h1234},
               {16'hffff, 16'h8000, 16'h7fff, 16'h0000}, 16'h0000);
    // Flat extremes at full-scale mu.
    send_group({4{16'h7fff}}, {4{16'h8000}}, 16'hffff);
    // Exact halves: I rounds +0.5 up to 1, Q rounds -0.5 up to 0.
    send_group({16'h0001, 16'h0001, 16'h0000, 16'h0000},
               {16'hffff, 16'hffff, 16'h0000, 16'h0000}, 16'h8000);
    send_group('0, '0, 16'hffff);
    send_group({16'h0000, 16'hffff, 16'haaaa, 16'h5555},
               {16'hffff, 16'h0000, 16'h5555, 16'haaaa}, 16'h5555);
    s_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);

    for (int g = 0; g < RANDOM_GROUPS; g++) begin
      if (g == 120) begin
        // Long output hold while the input keeps coming without gaps.
        s_valid = 1'b0;
        @(posedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
        tx_quiet = 1'b1;
      end
      if (g == 135)
        tx_quiet = 1'b0;
      if (g == 240) begin
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
      if (g == RANDOM_GROUPS - 50) begin
        // Final stretch runs at full rate on both sides.
        s_valid = 1'b0;
        @(posedge clk_i);
        rx_quiet = 1'b1;
        @(negedge clk_i);
        tx_quiet = 1'b1;
      end
      for (int k = 0; k < GROUP_LEN; k++) begin
        ri[k] = pick_sample();
        rq[k] = pick_sample();
      end
      send_group(ri, rq, pick_mu());
    end

    s_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Streamed %0d samples; %0d interpolated results checked, %0d channel outputs saturated.",
             sb.samples_taken, sb.results_checked, sb.saturated);
    $display("Included rail and rounding cases, idle bursts, a long output stall and a full drain.");
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches found", sb.errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
